// ===== hdl/thi_pkg.sv =====
package thi_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Depth of the queue between front and back, and of the result queue.
    localparam int QUEUE_DEPTH = 8;
    localparam int OUT_DEPTH   = 8;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_TILE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BOUND_LOW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BOUND_HIGH = 3'd5;

    localparam logic [31:0] RST_ORIGIN_X   = 32'h0000_0000;
    localparam logic [31:0] RST_ORIGIN_Z   = 32'h0000_0000;
    localparam logic [31:0] RST_INV_TILE   = 32'h0001_0000;  // 1.0
    localparam logic [8:0]  RST_ROW_LENGTH = 9'd256;
    localparam logic [31:0] RST_BOUND_LOW  = 32'hFF2E_0000;  // -210.0
    localparam logic [31:0] RST_BOUND_HIGH = 32'h022E_0000;  // 558.0

    // What the front decided about a request.
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_DROP,
        KIND_HIT,
        KIND_MISS
    } kind_t;

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_z;
        logic [31:0] inv_tile_spacing;
        logic [8:0]  row_length;
        logic [31:0] bound_low;
        logic [31:0] bound_high;
    } cfg_t;

endpackage

// ===== hdl/terrain_height_interpolator.sv =====
// Terrain height interpolator: a GRID_SIDE x GRID_SIDE store of signed Q16.16
// heights, filled by load requests and sampled by query requests that return
// one result each (found plus height; a miss returns zero). The block takes one
// request per clock while s_tready is high, loads and queries mixed freely, and
// results come out in request order. A query sees every load accepted before
// it. The front registers in turn the bounds test, the two 32x32 scale
// multiplies and the cell address; the back reads the four cell corners from
// two copies of the store (two read ports each, one write port shared by a
// load), picks the triangle, multiplies by the weights and sums. Each side
// stalls on its own: a queue of eight requests parts front and back, and a
// result queue of eight parts the back from m_tready.
module terrain_height_interpolator #(
    parameter int GRID_SIDE = thi_pkg::GRID_SIDE_DEF,
    parameter int FRAC_BITS = thi_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_index[15:0], height_value[47:16], pos_x[79:48], pos_z[111:80]
    input  logic [111:0]                       s_tdata,
    // req_type[0]
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // height[31:0]
    output logic [31:0]                        m_tdata,
    // found[0]
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [thi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_data
);
    import thi_pkg::*;

    localparam int NW     = $clog2(GRID_SIDE + 1);
    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int RW     = (NW > 9) ? NW : 9;
    localparam int QW     = 2 + ADDR_W + 32 + 2 * FRAC_BITS;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x         <= RST_ORIGIN_X;
            cfg_reg.origin_z         <= RST_ORIGIN_Z;
            cfg_reg.inv_tile_spacing <= RST_INV_TILE;
            cfg_reg.row_length       <= RST_ROW_LENGTH;
            cfg_reg.bound_low        <= RST_BOUND_LOW;
            cfg_reg.bound_high       <= RST_BOUND_HIGH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ORIGIN_X:   cfg_reg.origin_x         <= cfg_data;
                REG_ORIGIN_Z:   cfg_reg.origin_z         <= cfg_data;
                REG_INV_TILE:   cfg_reg.inv_tile_spacing <= cfg_data;
                REG_ROW_LENGTH: cfg_reg.row_length       <= cfg_data[8:0];
                REG_BOUND_LOW:  cfg_reg.bound_low        <= cfg_data;
                REG_BOUND_HIGH: cfg_reg.bound_high       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Row length in use, clipped to the grid side; below two nothing can hit.
    logic [RW-1:0] rl_ext;
    logic [NW-1:0] n_eff;
    logic          n_ok;

    always_comb begin
        rl_ext = RW'(cfg_reg.row_length);
        n_eff  = (rl_ext > RW'(GRID_SIDE)) ? NW'(GRID_SIDE) : NW'(rl_ext);
        n_ok   = (n_eff >= NW'(2));
    end

    logic                 f_push;
    kind_t                f_kind;
    logic [ADDR_W-1:0]    f_addr;
    logic [31:0]          f_data;
    logic [FRAC_BITS-1:0] f_fx, f_fz;
    logic                 q_pop, q_empty;

    thi_front #(
        .GRID_SIDE (GRID_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .n_eff        (n_eff),
        .n_ok         (n_ok),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tuser[0]),
        .cell_index   (s_tdata[15:0]),
        .height_value (s_tdata[47:16]),
        .pos_x        (s_tdata[79:48]),
        .pos_z        (s_tdata[111:80]),
        .q_push       (f_push),
        .q_kind       (f_kind),
        .q_addr       (f_addr),
        .q_data       (f_data),
        .q_fx         (f_fx),
        .q_fz         (f_fz),
        .q_pop        (q_pop)
    );

    logic [QW-1:0] q_wr_data, q_rd_data;

    assign q_wr_data = {f_kind, f_addr, f_data, f_fx, f_fz};

    thi_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (f_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    kind_t                b_kind;
    logic [ADDR_W-1:0]    b_addr;
    logic [31:0]          b_data;
    logic [FRAC_BITS-1:0] b_fx, b_fz;

    assign b_kind = kind_t'(q_rd_data[QW-1 -: 2]);
    assign b_addr = q_rd_data[QW-3 -: ADDR_W];
    assign b_data = q_rd_data[2*FRAC_BITS +: 32];
    assign b_fx   = q_rd_data[FRAC_BITS +: FRAC_BITS];
    assign b_fz   = q_rd_data[0 +: FRAC_BITS];

    logic        o_push, o_found, o_take, o_empty;
    logic [31:0] o_height;
    logic [32:0] o_rd_data;

    assign o_take = m_tvalid && m_tready;

    thi_back #(
        .GRID_SIDE (GRID_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .n_eff    (n_eff),
        .q_empty  (q_empty),
        .q_kind   (b_kind),
        .q_addr   (b_addr),
        .q_data   (b_data),
        .q_fx     (b_fx),
        .q_fz     (b_fz),
        .q_pop    (q_pop),
        .o_push   (o_push),
        .o_found  (o_found),
        .o_height (o_height),
        .o_take   (o_take)
    );

    thi_fifo #(
        .WIDTH (33),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (o_push),
        .wr_data ({o_found, o_height}),
        .rd_en   (o_take),
        .rd_data (o_rd_data),
        .empty   (o_empty)
    );

    assign m_tvalid = !o_empty;
    assign m_tdata  = o_rd_data[31:0];
    assign m_tuser  = o_rd_data[32];

endmodule

// ===== hdl/thi_fifo.sv =====
module thi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTRW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW:0]    cnt_reg;
    logic [PTRW:0]    cnt_next;

    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg + (PTRW+1)'(wr_en) - (PTRW+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + PTRW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/thi_front.sv =====
module thi_front #(
    parameter int GRID_SIDE = thi_pkg::GRID_SIDE_DEF,
    parameter int FRAC_BITS = thi_pkg::FRAC_BITS_DEF,
    parameter int NW        = $clog2(GRID_SIDE + 1),
    parameter int ADDR_W    = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  thi_pkg::cfg_t         cfg,
    input  logic [NW-1:0]         n_eff,
    input  logic                  n_ok,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [15:0]           cell_index,
    input  logic [31:0]           height_value,
    input  logic [31:0]           pos_x,
    input  logic [31:0]           pos_z,
    output logic                  q_push,
    output thi_pkg::kind_t        q_kind,
    output logic [ADDR_W-1:0]     q_addr,
    output logic [31:0]           q_data,
    output logic [FRAC_BITS-1:0]  q_fx,
    output logic [FRAC_BITS-1:0]  q_fz,
    input  logic                  q_pop
);
    import thi_pkg::*;

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int F     = FRAC_BITS;
    localparam int CXW   = 64 - 2 * F;
    localparam int PW    = 2 * NW;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    // Requests in flight in the front or waiting in the queue.
    logic [CW-1:0] cred_reg;
    logic [CW-1:0] cred_next;
    logic          accept;

    assign in_ready = (cred_reg < CW'(QUEUE_DEPTH));
    assign accept   = in_valid && in_ready;

    always_comb begin
        cred_next = cred_reg + CW'(accept) - CW'(q_pop);
    end

    // Stage 1: bounds test and offset from the grid origin.
    logic signed [31:0] x_s, z_s, lo_s, hi_s;
    logic               oob;
    logic [32:0]        ux, uz;
    logic               ld_ok;

    always_comb begin
        x_s   = $signed(pos_x);
        z_s   = $signed(pos_z);
        lo_s  = $signed(cfg.bound_low);
        hi_s  = $signed(cfg.bound_high);
        oob   = (x_s < lo_s) || (z_s < lo_s) || (x_s > hi_s) || (z_s > hi_s);
        ux    = {pos_x[31], pos_x} - {cfg.origin_x[31], cfg.origin_x};
        uz    = {pos_z[31], pos_z} - {cfg.origin_z[31], cfg.origin_z};
        ld_ok = (32'(cell_index) < 32'(DEPTH));
    end

    logic              s1_vld_reg;
    logic              s1_load_reg;
    logic              s1_ok_reg;
    logic              s1_miss_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [31:0]       s1_data_reg;
    logic [32:0]       s1_ux_reg;
    logic [32:0]       s1_uz_reg;

    // Stage 2: scale by the reciprocal of the tile spacing.
    logic              s2_vld_reg;
    logic              s2_load_reg;
    logic              s2_ok_reg;
    logic              s2_miss_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [31:0]       s2_data_reg;
    logic [63:0]       s2_px_reg;
    logic [63:0]       s2_pz_reg;

    // Stage 3: cell, fractions and base address.
    logic [CXW-1:0]    cx, cz, lim;
    logic              far;
    logic [PW-1:0]     row_off;
    logic [ADDR_W-1:0] base;
    kind_t             kind_next;

    always_comb begin
        cx      = s2_px_reg[63:2*F];
        cz      = s2_pz_reg[63:2*F];
        lim     = CXW'(n_eff) - CXW'(2);
        far     = (cx > lim) || (cz > lim);
        row_off = PW'(cz[NW-1:0]) * PW'(n_eff);
        base    = ADDR_W'(row_off + PW'(cx[NW-1:0]));
        if (s2_load_reg) begin
            kind_next = s2_ok_reg ? KIND_WRITE : KIND_DROP;
        end else begin
            kind_next = (s2_miss_reg || far) ? KIND_MISS : KIND_HIT;
        end
    end

    logic q_push_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cred_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            q_push_reg <= 1'b0;
        end else begin
            cred_reg   <= cred_next;
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            q_push_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_load_reg <= !req_type;
        s1_ok_reg   <= ld_ok;
        s1_miss_reg <= oob || !n_ok;
        s1_addr_reg <= ADDR_W'(cell_index);
        s1_data_reg <= height_value;
        s1_ux_reg   <= ux;
        s1_uz_reg   <= uz;

        s2_load_reg <= s1_load_reg;
        s2_ok_reg   <= s1_ok_reg;
        s2_miss_reg <= s1_miss_reg || s1_ux_reg[32] || s1_uz_reg[32];
        s2_addr_reg <= s1_addr_reg;
        s2_data_reg <= s1_data_reg;
        s2_px_reg   <= 64'(s1_ux_reg[31:0]) * 64'(cfg.inv_tile_spacing);
        s2_pz_reg   <= 64'(s1_uz_reg[31:0]) * 64'(cfg.inv_tile_spacing);

        q_kind <= kind_next;
        q_addr <= s2_load_reg ? s2_addr_reg : base;
        q_data <= s2_data_reg;
        q_fx   <= s2_px_reg[2*F-1:F];
        q_fz   <= s2_pz_reg[2*F-1:F];
    end

    assign q_push = q_push_reg;

endmodule

// ===== hdl/thi_back.sv =====
module thi_back #(
    parameter int GRID_SIDE = thi_pkg::GRID_SIDE_DEF,
    parameter int FRAC_BITS = thi_pkg::FRAC_BITS_DEF,
    parameter int NW        = $clog2(GRID_SIDE + 1),
    parameter int ADDR_W    = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [NW-1:0]         n_eff,
    input  logic                  q_empty,
    input  thi_pkg::kind_t        q_kind,
    input  logic [ADDR_W-1:0]     q_addr,
    input  logic [31:0]           q_data,
    input  logic [FRAC_BITS-1:0]  q_fx,
    input  logic [FRAC_BITS-1:0]  q_fz,
    output logic                  q_pop,
    output logic                  o_push,
    output logic                  o_found,
    output logic [31:0]           o_height,
    input  logic                  o_take
);
    import thi_pkg::*;

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int F     = FRAC_BITS;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam int PRW   = 35 + F;
    localparam int AW    = PRW + 1;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [AW-1:0] YMAX = AW'($signed(32'h7FFF_FFFF));
    localparam logic signed [AW-1:0] YMIN = AW'($signed(32'h8000_0000));

    // Queries taken from the queue whose results are not yet delivered.
    logic [OCW-1:0] ocnt_reg;
    logic [OCW-1:0] ocnt_next;
    logic           pop_query;

    assign q_pop     = !q_empty && (ocnt_reg < OCW'(OUT_DEPTH));
    assign pop_query = q_pop && ((q_kind == KIND_HIT) || (q_kind == KIND_MISS));

    always_comb begin
        ocnt_next = ocnt_reg + OCW'(pop_query) - OCW'(o_take);
    end

    // Two copies of the store, each with two read ports, give all four corners
    // in the same cycle. Every load within the store writes both copies.
    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];

    logic              b1_vld_reg;
    kind_t             b1_kind_reg;
    logic [ADDR_W-1:0] b1_a0_reg, b1_a1_reg, b1_a2_reg, b1_a3_reg;
    logic [31:0]       b1_data_reg;
    logic [F-1:0]      b1_fx_reg, b1_fz_reg;

    logic              b2_vld_reg;
    kind_t             b2_kind_reg;
    logic [F-1:0]      b2_fx_reg, b2_fz_reg;
    logic [31:0]       h0_reg, h1_reg, h2_reg, h3_reg;

    logic              b3_vld_reg;
    kind_t             b3_kind_reg;
    logic [31:0]       b3_hb_reg;
    logic [32:0]       b3_d1_reg, b3_d2_reg;
    logic [F:0]        b3_w1_reg, b3_w2_reg;

    logic                  b4_vld_reg;
    kind_t                 b4_kind_reg;
    logic [31:0]           b4_hb_reg;
    logic signed [PRW-1:0] b4_p1_reg, b4_p2_reg;

    // Triangle choice: the corner 0 triangle holds points with fx + fz below one.
    logic        lower;
    logic [31:0] hb;
    logic [32:0] d1, d2;
    logic [F:0]  w1, w2;

    always_comb begin
        lower = (({1'b0, b2_fx_reg} + {1'b0, b2_fz_reg}) < ONE);
        hb    = lower ? h0_reg : h3_reg;
        d1    = {h1_reg[31], h1_reg} - {hb[31], hb};
        d2    = {h2_reg[31], h2_reg} - {hb[31], hb};
        w1    = lower ? {1'b0, b2_fz_reg} : ONE - {1'b0, b2_fx_reg};
        w2    = lower ? {1'b0, b2_fx_reg} : ONE - {1'b0, b2_fz_reg};
    end

    logic signed [AW-1:0] acc, acc_sh, y;
    logic [31:0]          y_sat;

    always_comb begin
        acc    = AW'(b4_p1_reg) + AW'(b4_p2_reg);
        acc_sh = acc >>> F;
        y      = acc_sh + AW'($signed(b4_hb_reg));
        if (y > YMAX) begin
            y_sat = 32'h7FFF_FFFF;
        end else if (y < YMIN) begin
            y_sat = 32'h8000_0000;
        end else begin
            y_sat = y[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg   <= '0;
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
        end else begin
            ocnt_reg   <= ocnt_next;
            b1_vld_reg <= q_pop;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            b4_vld_reg <= b3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        b1_kind_reg <= q_kind;
        b1_a0_reg   <= q_addr;
        b1_a1_reg   <= q_addr + ADDR_W'(n_eff);
        b1_a2_reg   <= q_addr + ADDR_W'(1);
        b1_a3_reg   <= q_addr + ADDR_W'(n_eff) + ADDR_W'(1);
        b1_data_reg <= q_data;
        b1_fx_reg   <= q_fx;
        b1_fz_reg   <= q_fz;

        b2_kind_reg <= b1_kind_reg;
        b2_fx_reg   <= b1_fx_reg;
        b2_fz_reg   <= b1_fz_reg;

        b3_kind_reg <= b2_kind_reg;
        b3_hb_reg   <= hb;
        b3_d1_reg   <= d1;
        b3_d2_reg   <= d2;
        b3_w1_reg   <= w1;
        b3_w2_reg   <= w2;

        b4_kind_reg <= b3_kind_reg;
        b4_hb_reg   <= b3_hb_reg;
        b4_p1_reg   <= PRW'($signed(b3_d1_reg)) * PRW'($signed({1'b0, b3_w1_reg}));
        b4_p2_reg   <= PRW'($signed(b3_d2_reg)) * PRW'($signed({1'b0, b3_w2_reg}));
    end

    always_ff @(posedge aclk) begin
        if (b1_vld_reg && (b1_kind_reg == KIND_WRITE)) begin
            mem_a[b1_a0_reg] <= b1_data_reg;
            mem_b[b1_a0_reg] <= b1_data_reg;
        end
        h0_reg <= mem_a[b1_a0_reg];
        h2_reg <= mem_a[b1_a2_reg];
        h1_reg <= mem_b[b1_a1_reg];
        h3_reg <= mem_b[b1_a3_reg];
    end

    assign o_push   = b4_vld_reg && ((b4_kind_reg == KIND_HIT) || (b4_kind_reg == KIND_MISS));
    assign o_found  = (b4_kind_reg == KIND_HIT);
    assign o_height = (b4_kind_reg == KIND_HIT) ? y_sat : 32'h0000_0000;

endmodule

// ===== dv/tb_terrain_height_interpolator.sv =====
`timescale 1ns / 100ps

module tb_terrain_height_interpolator;
    import thi_pkg::*;

    localparam int     GRID_SIDE        = GRID_SIDE_DEF;
    localparam int     FRAC_BITS        = FRAC_BITS_DEF;
    localparam longint ONE_FRAC         = longint'(1) << FRAC_BITS;
    localparam longint HEIGHT_MAX       = 64'sd2147483647;
    localparam longint HEIGHT_MIN       = -64'sd2147483648;
    localparam int     DRAIN_CYCLES     = 40;
    localparam int     WATCHDOG_LIMIT   = 2000;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     N_DIRECTED       = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic {
        REQ_LOAD,
        REQ_QUERY
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [15:0] idx;
        logic [31:0] hval;
        logic [31:0] px;
        logic [31:0] pz;
    } terrain_req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] height;
    } terrain_result_t;

    typedef struct packed {
        terrain_req_t    rq;
        logic            typed;
        terrain_result_t res;
    } directed_row_t;

    typedef struct {
        bit          hit;
        int unsigned base;
        int unsigned n;
        longint      fx;
        longint      fz;
    } cell_loc_t;

    // Reset configuration: origin 0, spacing 1.0, 256 points a side, bounds -210.0 to 558.0.
    // Rows flagged typed carry an expectation that follows directly from the corner heights.
    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        '{'{REQ_LOAD,  16'h0000, 32'h7FFF_FFFF, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_LOAD,  16'h0001, 32'h8000_0000, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_LOAD,  16'h0100, 32'h0000_0000, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_LOAD,  16'h0101, 32'h0001_0000, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{1'b1, 32'h7FFF_FFFF}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_8000, 32'h0000_0000}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_C000, 32'h0000_C000}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_FFFF, 32'h0000_0001}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_7FFF, 32'h0000_8000}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'hFFFF_0000, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h022E_0001, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_0000, 32'h022E_0001}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h00FF_0000, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h0000_0000, 32'h00FF_8000}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_LOAD,  16'hFEFE, 32'h1234_5678, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_LOAD,  16'hFEFF, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_LOAD,  16'hFFFE, 32'h8000_0001, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_LOAD,  16'hFFFF, 32'h7FFF_FFFE, 32'h0, 32'h0}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h00FE_FFFF, 32'h00FE_FFFF}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h00FE_0000, 32'h00FE_0000}, 1'b1, '{1'b1, 32'h1234_5678}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'h022E_0000, 32'h022E_0000}, 1'b1, '{1'b0, 32'h0}},
        '{'{REQ_QUERY, 16'h0, 32'h0, 32'hFF2E_0000, 32'h0000_0000}, 1'b1, '{1'b0, 32'h0}}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [111:0]           s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;

    cfg_t            cfg_shadow;
    logic [31:0]     height_mem [0:65535];
    bit              height_written [0:65535];
    terrain_result_t pending_heights [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int hits_checked    = 0;
    int loads_sent      = 0;
    int settings_used   = 1;
    int src_idle_pct    = 0;
    int snk_idle_pct    = 0;
    int long_hold_req   = 0;
    int long_hold_seen  = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    terrain_height_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Finds the cell under a world position and the point's fractions inside it.
    function automatic cell_loc_t locate_cell(input logic [31:0] px, input logic [31:0] pz);
        cell_loc_t         loc;
        longint            x, z, ux, uz;
        logic [63:0]       ax, az, sx, sz;
        longint unsigned   cx, cz;
        int unsigned       n;
        loc = '{hit: 1'b0, base: 0, n: 0, fx: 0, fz: 0};
        x = $signed(px);
        z = $signed(pz);
        if (x < $signed(cfg_shadow.bound_low) || z < $signed(cfg_shadow.bound_low) ||
            x > $signed(cfg_shadow.bound_high) || z > $signed(cfg_shadow.bound_high))
            return loc;
        n = (cfg_shadow.row_length > GRID_SIDE) ? GRID_SIDE : cfg_shadow.row_length;
        if (n < 2)
            return loc;
        ux = x - $signed(cfg_shadow.origin_x);
        uz = z - $signed(cfg_shadow.origin_z);
        if (ux < 0 || uz < 0)
            return loc;
        ax = ux;
        az = uz;
        sx = ax * 64'(cfg_shadow.inv_tile_spacing);
        sz = az * 64'(cfg_shadow.inv_tile_spacing);
        cx = sx >> (2 * FRAC_BITS);
        cz = sz >> (2 * FRAC_BITS);
        if (cx > longint'(n - 2) || cz > longint'(n - 2))
            return loc;
        loc.hit  = 1'b1;
        loc.n    = n;
        loc.base = cz * n + cx;
        loc.fx   = (sx >> FRAC_BITS) & (ONE_FRAC - 1);
        loc.fz   = (sz >> FRAC_BITS) & (ONE_FRAC - 1);
        return loc;
    endfunction

    // Picks the lower or upper triangle and blends its three corners, with a floored shift.
    function automatic logic [31:0] interp_height(input cell_loc_t loc);
        longint h0, h1, h2, h3, acc, y;
        h0 = $signed(height_mem[loc.base]);
        h1 = $signed(height_mem[loc.base + loc.n]);
        h2 = $signed(height_mem[loc.base + 1]);
        h3 = $signed(height_mem[loc.base + loc.n + 1]);
        if (loc.fx + loc.fz < ONE_FRAC) begin
            acc = loc.fz * (h1 - h0) + loc.fx * (h2 - h0);
            y   = h0 + (acc >>> FRAC_BITS);
        end else begin
            acc = (ONE_FRAC - loc.fx) * (h1 - h3) + (ONE_FRAC - loc.fz) * (h2 - h3);
            y   = h3 + (acc >>> FRAC_BITS);
        end
        if (y > HEIGHT_MAX)
            y = HEIGHT_MAX;
        if (y < HEIGHT_MIN)
            y = HEIGHT_MIN;
        return y[31:0];
    endfunction

    // A random coordinate within the span the grid covers from the given origin.
    function automatic logic [31:0] near_grid(input logic [31:0] org);
        longint unsigned span;
        longint          p;
        int unsigned     n;
        n = (cfg_shadow.row_length > GRID_SIDE) ? GRID_SIDE : cfg_shadow.row_length;
        if (n < 2)
            n = 4;
        if (cfg_shadow.inv_tile_spacing == 0)
            span = 64'd100 << FRAC_BITS;
        else
            span = (64'(n - 1) << (2 * FRAC_BITS)) / cfg_shadow.inv_tile_spacing;
        p = $signed(org) + longint'({$urandom, $urandom} % (span + 1));
        if (p > HEIGHT_MAX)
            p = HEIGHT_MAX;
        return p[31:0];
    endfunction

    function automatic logic [31:0] random_height();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    endfunction

    task automatic send_request(input terrain_req_t rq, input bit typed = 1'b0,
                                input terrain_result_t typed_res = '0);
        terrain_result_t res;
        cell_loc_t       loc;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= {rq.pz, rq.px, rq.hval, rq.idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (rq.kind == REQ_LOAD) begin
            height_mem[rq.idx]     = rq.hval;
            height_written[rq.idx] = 1'b1;
            loads_sent++;
        end else if (typed) begin
            pending_heights.insert(pending_heights.size(), typed_res);
        end else begin
            loc        = locate_cell(rq.px, rq.pz);
            res.found  = loc.hit;
            res.height = loc.hit ? interp_height(loc) : 32'h0;
            pending_heights.insert(pending_heights.size(), res);
        end
    endtask

    task automatic write_config(input cfg_t c, input bit poke_unused);
        logic [CFG_INDEX_W-1:0] order [7];
        logic [31:0]            word;
        int                     k;
        order = '{REG_ORIGIN_X, REG_ORIGIN_Z, REG_INV_TILE, REG_ROW_LENGTH,
                  REG_BOUND_LOW, REG_BOUND_HIGH, REG_UNUSED};
        for (k = 0; k < (poke_unused ? 7 : 6); k++) begin
            case (order[k])
                REG_ORIGIN_X:   word = c.origin_x;
                REG_ORIGIN_Z:   word = c.origin_z;
                REG_INV_TILE:   word = c.inv_tile_spacing;
                REG_ROW_LENGTH: word = {23'($urandom), c.row_length};
                REG_BOUND_LOW:  word = c.bound_low;
                REG_BOUND_HIGH: word = c.bound_high;
                default:        word = $urandom;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= word;
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            case (order[k])
                REG_ORIGIN_X:   cfg_shadow.origin_x         = word;
                REG_ORIGIN_Z:   cfg_shadow.origin_z         = word;
                REG_INV_TILE:   cfg_shadow.inv_tile_spacing = word;
                REG_ROW_LENGTH: cfg_shadow.row_length       = word[8:0];
                REG_BOUND_LOW:  cfg_shadow.bound_low        = word;
                REG_BOUND_HIGH: cfg_shadow.bound_high       = word;
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_results();
        while (pending_heights.size() != 0)
            @(posedge aclk);
    endtask

    // One register setting followed by a mix of grid queries, wild queries and stray loads.
    task automatic run_phase(input cfg_t c, input int src_pct, input int snk_pct,
                             input int n_items, input bit poke_unused,
                             input bit hold_receiver, input bit pause_sender);
        terrain_req_t rq;
        cell_loc_t    loc;
        int unsigned  corners [4];
        int           items_left;
        int           pick;
        int           k;
        bit           hold_done;
        bit           pause_done;
        // Loads leave no result behind, so give the pipeline time to retire them too.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_config(c, poke_unused);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        items_left   = n_items;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        while (items_left > 0) begin
            // A query may bring corner loads along, so the count can step over a mark.
            if (hold_receiver && !hold_done && items_left <= n_items - 10) begin
                long_hold_req++;
                hold_done = 1'b1;
            end
            if (pause_sender && !pause_done && items_left <= n_items / 2) begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait_results();
            end
            pick = $urandom_range(99);
            rq.idx  = $urandom;
            rq.hval = random_height();
            rq.px   = $urandom;
            rq.pz   = $urandom;
            if (pick < 15) begin
                rq.kind = REQ_LOAD;
                send_request(rq);
                items_left--;
            end else begin
                rq.kind = REQ_QUERY;
                if (pick >= 30) begin
                    rq.px = near_grid(cfg_shadow.origin_x);
                    rq.pz = near_grid(cfg_shadow.origin_z);
                end
                loc = locate_cell(rq.px, rq.pz);
                if (loc.hit) begin
                    corners = '{loc.base, loc.base + loc.n, loc.base + 1, loc.base + loc.n + 1};
                    for (k = 0; k < 4; k++) begin
                        if (!height_written[corners[k]] || $urandom_range(7) == 0) begin
                            send_request('{REQ_LOAD, corners[k][15:0], random_height(),
                                           32'($urandom), 32'($urandom)});
                            items_left--;
                        end
                    end
                end
                send_request(rq);
                items_left--;
            end
        end
    endtask

    // Result side: random back-pressure, the long hold-off on request, and the comparison.
    always @(posedge aclk) begin
        terrain_result_t want;
        if (long_hold_req != long_hold_seen) begin
            long_hold_seen = long_hold_req;
            hold_left      = LONG_HOLD_CYCLES;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_heights.size() == 0) begin
                report_mismatch($sformatf("result found=%0d height=%h with none pending",
                                          m_tuser[0], m_tdata));
            end else begin
                want = pending_heights.pop_front();
                if (m_tuser[0] !== want.found)
                    report_mismatch($sformatf("found %0d, want %0d", m_tuser[0], want.found));
                if (m_tdata !== want.height)
                    report_mismatch($sformatf("height %h, want %h", m_tdata, want.height));
                results_checked++;
                if (want.found)
                    hits_checked++;
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] Timeout: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cfg_t c;
        int   r;
        int   k;
        cfg_shadow = '{origin_x: RST_ORIGIN_X, origin_z: RST_ORIGIN_Z,
                       inv_tile_spacing: RST_INV_TILE, row_length: RST_ROW_LENGTH,
                       bound_low: RST_BOUND_LOW, bound_high: RST_BOUND_HIGH};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 16;
        snk_idle_pct = 82;
        for (r = 0; r < N_DIRECTED; r++)
            send_request(DIRECTED[r].rq, DIRECTED[r].typed, DIRECTED[r].res);

        // Small grid at unit spacing, offset origin, tight bounds.
        c = cfg_shadow;
        c.origin_x = 32'hFFFB_0000;
        c.origin_z = 32'h0003_4000;
        c.inv_tile_spacing = 32'h0001_0000;
        c.row_length = 9'd8;
        c.bound_low  = 32'hFFF6_0000;
        c.bound_high = 32'h0014_0000;
        run_phase(c, 16, 82, 60, 1'b0, 1'b0, 1'b0);

        // Spacing 2.0, widest bounds, random origin.
        c.origin_x = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        c.origin_z = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        c.inv_tile_spacing = 32'h0000_8000;
        c.row_length = 9'd16;
        c.bound_low  = 32'h8000_0000;
        c.bound_high = 32'h7FFF_FFFF;
        run_phase(c, 16, 82, 60, 1'b1, 1'b0, 1'b0);

        // Most negative origin with a tiny reciprocal: offsets span the whole 32-bit range.
        c.origin_x = 32'h8000_0000;
        c.origin_z = 32'h8000_0000;
        c.inv_tile_spacing = 32'h0000_0100;
        c.row_length = 9'd256;
        run_phase(c, 16, 82, 50, 1'b0, 1'b0, 1'b0);

        // Zero reciprocal: everything in bounds at or past the origin lands on the first corner.
        c.origin_x = 32'h0;
        c.origin_z = 32'h0;
        c.inv_tile_spacing = 32'h0;
        c.row_length = 9'd3;
        c.bound_low  = 32'hFF9C_0000;
        c.bound_high = 32'h0064_0000;
        run_phase(c, 82, 16, 50, 1'b0, 1'b0, 1'b0);

        // Largest reciprocal, row length beyond the grid, reset bounds.
        c.origin_x = 32'($urandom_range(0, 32'h0100_0000));
        c.origin_z = 32'($urandom_range(0, 32'h0100_0000));
        c.inv_tile_spacing = 32'hFFFF_FFFF;
        c.row_length = 9'h1FF;
        c.bound_low  = RST_BOUND_LOW;
        c.bound_high = RST_BOUND_HIGH;
        run_phase(c, 82, 16, 50, 1'b0, 1'b0, 1'b0);

        // Row length zero: every query misses.
        c.origin_x = 32'h0;
        c.origin_z = 32'h0;
        c.inv_tile_spacing = 32'($urandom_range(32'h4000, 32'h4_0000));
        c.row_length = 9'd0;
        run_phase(c, 82, 16, 30, 1'b0, 1'b0, 1'b0);

        // No idling; the result side holds off long enough to back up the input.
        c.origin_x = 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        c.origin_z = 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        c.inv_tile_spacing = 32'($urandom_range(32'h8000, 32'h3_0000));
        c.row_length = 9'($urandom_range(2, 32));
        c.bound_low  = 32'h8000_0000;
        c.bound_high = 32'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
        run_phase(c, 0, 0, 70, 1'b0, 1'b1, 1'b0);

        // Smallest usable grid, with the sender waiting for all results halfway.
        c.origin_x = 32'h0;
        c.origin_z = 32'h0;
        c.inv_tile_spacing = 32'h0001_0000;
        c.row_length = 9'd2;
        c.bound_low  = RST_BOUND_LOW;
        c.bound_high = RST_BOUND_HIGH;
        run_phase(c, 0, 0, 40, 1'b0, 1'b0, 1'b1);

        c.row_length = 9'd1;
        run_phase(c, 0, 0, 20, 1'b0, 1'b0, 1'b0);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (k = 0; k < 20000 && pending_heights.size() != 0; k++)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_heights.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_heights.size()));

        $display("Checked %0d query results (%0d on the grid) after %0d height loads,",
                 results_checked, hits_checked, loads_sent);
        $display("across %0d register settings with idle, stall and hold-off patterns.",
                 settings_used);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== terrain_height_interpolator.f =====
hdl/thi_pkg.sv
hdl/thi_fifo.sv
hdl/thi_front.sv
hdl/thi_back.sv
hdl/terrain_height_interpolator.sv
dv/tb_terrain_height_interpolator.sv
